### rtl/boxcar_decimator_sample_fifo_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the boxcar decimator sample FIFO core
// Uses the module's clock and reset port names: clock, reset.
// ----------------------------------------------------------------------------
`ifndef BOXCAR_DECIMATOR_SAMPLE_FIFO_CORE_DEFINES_SVH
`define BOXCAR_DECIMATOR_SAMPLE_FIFO_CORE_DEFINES_SVH

// Check a property at every rising clock edge outside reset
`define BDSF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle
`define BDSF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/bdsf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsf_pkg
// Command codes and fixed field widths of the boxcar decimator sample FIFO.
// ----------------------------------------------------------------------------
package bdsf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int CMD_W    = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_SAMPLE = 2'd0,
      CMD_READ   = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

endpackage

### rtl/boxcar_decimator_sample_fifo_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boxcar_decimator_sample_fifo_core
// Boxcar average over DECIMATION samples, pushed into a FIFO; reads pop it.
// ----------------------------------------------------------------------------
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------------
//   req     | in        | req_valid, req_stall, req_cmd, req_sample
//   rsp     | out       | rsp_valid, rsp_stall, rsp_read_value, rsp_read_valid,
//           |           | rsp_dropped, rsp_level, rsp_not_empty
//
// One item per cycle while rsp is not stalled; each result passes through
// the read stage (state update and FIFO RAM read at the transfer edge) and
// then the result register before it can transfer.
// The running sum, reciprocal multiply and FIFO pointers update in the
// transfer cycle, so back-to-back items see each other's effects.
// Reset is synchronous; the FIFO RAM is not cleared, pointers and count are.
// A stall on rsp fills the result and the read stage, then stalls req.
// ----------------------------------------------------------------------------
`include "boxcar_decimator_sample_fifo_core_defines.svh"

module boxcar_decimator_sample_fifo_core
   import bdsf_pkg::*;
#(
   parameter int DECIMATION = 4,
   parameter int FIFO_DEPTH = 64,
   localparam int LEVEL_W   = $clog2(FIFO_DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_cmd,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_read_value,
   output logic                       rsp_read_valid,
   output logic                       rsp_dropped,
   output logic [LEVEL_W-1:0]         rsp_level,
   output logic                       rsp_not_empty
);

   // Derived widths and constants
   localparam int LOG_D   = $clog2(DECIMATION);
   localparam int SUM_W   = SAMPLE_W + LOG_D;
   localparam int PH_W    = (DECIMATION > 1) ? LOG_D : 1;
   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int SHIFT   = SUM_W + LOG_D;
   localparam int PROD_W  = 2 * SUM_W + 1;
   localparam longint RECIP_L = ((longint'(1) << SHIFT) + DECIMATION - 1) / DECIMATION;
   localparam logic [SUM_W:0]       RECIP      = (SUM_W + 1)'(RECIP_L);
   localparam logic [PH_W-1:0]      PHASE_LAST = PH_W'(DECIMATION - 1);
   localparam logic [PTR_W-1:0]     PTR_LAST   = PTR_W'(FIFO_DEPTH - 1);
   localparam logic [LEVEL_W-1:0]   FILL_FULL  = LEVEL_W'(FIFO_DEPTH);

   // Decimator and FIFO control state
   logic [PH_W-1:0]          phase_ff,   phase_in;
   logic signed [SUM_W-1:0]  sum_ff,     sum_in;
   logic [PTR_W-1:0]         wr_ptr_ff,  wr_ptr_in;
   logic [PTR_W-1:0]         rd_ptr_ff,  rd_ptr_in;
   logic [LEVEL_W-1:0]       fill_ff,    fill_in;

   // FIFO storage
   logic signed [SAMPLE_W-1:0] fifo_mem [FIFO_DEPTH];

   // Read stage
   logic                       a_valid_ff, a_valid_in;
   logic                       a_pop_ff;
   logic                       a_drop_ff;
   logic [LEVEL_W-1:0]         a_level_ff;
   logic signed [SAMPLE_W-1:0] a_rdata_ff;

   // Result stage
   logic                       rsp_valid_ff,      rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic                       rsp_read_valid_ff;
   logic                       rsp_dropped_ff;
   logic [LEVEL_W-1:0]         rsp_level_ff;
   logic                       rsp_not_empty_ff;

   // Step datapath
   cmd_type                    cmd;
   logic                       req_xfer;
   logic                       a_move;
   logic                       push;
   logic                       pop;
   logic                       drop;
   logic signed [SUM_W-1:0]    sum_add;
   logic [SUM_W-1:0]           mag;
   logic [PROD_W-1:0]          prod;
   logic [SAMPLE_W-1:0]        quot;
   logic signed [SAMPLE_W-1:0] avg;

   // Handshake: read stage advances when the result slot is free or drains
   assign a_move    = a_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = a_valid_ff && !a_move;
   assign req_xfer  = req_valid && !req_stall;
   assign cmd       = cmd_type'(req_cmd);

   // Average: exact reciprocal multiply on the magnitude, truncating toward zero
   always_comb begin
      sum_add = sum_ff + SUM_W'(req_sample);
      mag     = sum_add[SUM_W-1] ? $unsigned(-sum_add) : $unsigned(sum_add);
      prod    = PROD_W'(mag) * PROD_W'(RECIP);
      quot    = prod[SHIFT +: SAMPLE_W];
      avg     = sum_add[SUM_W-1] ? $signed(-quot) : $signed(quot);
   end

   // Decode the command and compute the next control state
   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      push      = 1'b0;
      pop       = 1'b0;
      drop      = 1'b0;
      unique case (cmd)
         CMD_SAMPLE: begin
            if (phase_ff == PHASE_LAST) begin
               phase_in = '0;
               sum_in   = '0;
               if (fill_ff != FILL_FULL) begin
                  push      = 1'b1;
                  wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
                  fill_in   = fill_ff + 1'b1;
               end else begin
                  drop = 1'b1;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
               sum_in   = sum_add;
            end
         end
         CMD_READ: begin
            if (fill_ff != '0) begin
               pop       = 1'b1;
               rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
               fill_in   = fill_ff - 1'b1;
            end
         end
         CMD_CLEAR: begin
            phase_in  = '0;
            sum_in    = '0;
            wr_ptr_in = '0;
            rd_ptr_in = '0;
            fill_in   = '0;
         end
         default: begin
         end
      endcase
   end

   // Advance the control state on a request transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= '0;
         sum_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else if (req_xfer) begin
         phase_ff  <= phase_in;
         sum_ff    <= sum_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // FIFO RAM: write the new average, read the oldest entry into the read stage
   always_ff @(posedge clock) begin
      if (req_xfer && push) begin
         fifo_mem[wr_ptr_ff] <= avg;
      end
      if (req_xfer && pop) begin
         a_rdata_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   // Read stage: hold flags until the result register takes them
   assign a_valid_in = req_xfer ? 1'b1 : (a_move ? 1'b0 : a_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
      if (req_xfer) begin
         a_pop_ff   <= pop;
         a_drop_ff  <= drop;
         a_level_ff <= fill_in;
      end
   end

   // Result register: load from the read stage, hold while stalled
   assign rsp_valid_in      = a_move ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_read_value_in = a_pop_ff ? a_rdata_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (a_move) begin
         rsp_read_value_ff <= rsp_read_value_in;
         rsp_read_valid_ff <= a_pop_ff;
         rsp_dropped_ff    <= a_drop_ff;
         rsp_level_ff      <= a_level_ff;
         rsp_not_empty_ff  <= (a_level_ff != '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_read_valid = rsp_read_valid_ff;
   assign rsp_dropped    = rsp_dropped_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_not_empty  = rsp_not_empty_ff;

   // Checks on FIFO bookkeeping and the stage handoff
   `BDSF_ASSERT(a_fill_bound, fill_ff <= FILL_FULL, "fill count above FIFO depth")
   `BDSF_ASSERT(a_ptr_empty,
      (fill_ff != '0) || (wr_ptr_ff == rd_ptr_ff),
      "empty FIFO with split pointers")
   `BDSF_ASSERT(a_one_event,
      !(rsp_valid_ff && rsp_read_valid_ff && rsp_dropped_ff),
      "pop and drop in one result")
   `BDSF_ASSERT_NEXT(a_clear_empty,
      req_xfer && (cmd == CMD_CLEAR), fill_ff == '0,
      "clear left FIFO entries")
   `BDSF_ASSERT_NEXT(a_stage_hold,
      a_valid_ff && rsp_valid_ff && rsp_stall, a_valid_ff,
      "read stage lost an item under stall")

endmodule
